// ===== hdl/transactional_key_value_table_top_assert.svh =====
// Assertion macros used by the port checker file.
`ifndef TRANSACTIONAL_KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define TRANSACTIONAL_KEY_VALUE_TABLE_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TKV_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define TKV_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== hdl/tkv_pkg.sv =====
// Package: types, constants and command codes of the key/value table.
package tkv_pkg;
	localparam int TABLE_DEPTH_D = 64;
	localparam int LOG_DEPTH_D = 32;
	localparam int KEY_BITS_D = 64;

	typedef enum logic [2:0] {
		CMD_GET = 3'd0, CMD_PUT = 3'd1, CMD_INC = 3'd2, CMD_DEL = 3'd3,
		CMD_START = 3'd4, CMD_COMMIT = 3'd5, CMD_ABORT = 3'd6, CMD_NONE = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE = 3'd0, ST_ABSENT = 3'd1, ST_TABLE_FULL = 3'd2,
		ST_LOG_FULL = 3'd3, ST_NO_TRANS = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0] command;
		logic [63:0] key;
		logic signed [31:0] new_value;
		logic new_exists;
	} in_item_t;

	typedef struct packed {
		logic exists;
		logic signed [31:0] result_value;
		logic [2:0] status;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_ACT, S_UNDO_RD, S_UNDO_WR, S_OUT
	} fsm_t;
endpackage

// ===== hdl/transactional_key_value_table_top.sv =====
// Top level of the transactional key/value table.
// Channels: in (valid/stall, in_item_t) carries one command item, out
// (valid/stall, out_item_t) carries exactly one result item per command.
// Keys and values live in synchronous RAMs; the key RAM is read one entry
// per cycle and compared in the following cycle. Used and exists flags are
// flip-flops cleared at reset. The undo log (index, old flag, old value)
// sits in a second set of RAMs.
// Get/put/increment/delete scan the whole key table before acting; start,
// commit and command 7 go straight to the result; an abort inside a
// transaction walks the log newest first, reading each entry, then undoing it.
// One command is in flight at a time; in_stall is high while busy or while
// a result waits. When out_stall is high the result holds in its register
// until taken. Reset clears the flags, the log count and the transaction
// mark; no clearing pass is needed.
module transactional_key_value_table_top #(
	parameter int TABLE_DEPTH = tkv_pkg::TABLE_DEPTH_D,
	parameter int LOG_DEPTH = tkv_pkg::LOG_DEPTH_D,
	parameter int KEY_BITS = tkv_pkg::KEY_BITS_D
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input tkv_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output tkv_pkg::out_item_t out_item
);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CW = $clog2(LOG_DEPTH + 1);
	localparam int TW = $clog2(TABLE_DEPTH + 1);

	tkv_pkg::fsm_t state_q, state_d;

	logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] used_q, ex_q;
	logic [31:0] val_mem [TABLE_DEPTH];
	logic [IW-1:0] ulog_idx [LOG_DEPTH];
	logic ulog_ex [LOG_DEPTH];
	logic [31:0] ulog_val [LOG_DEPTH];

	logic [CW-1:0] cnt_q;
	logic trans_q;
	tkv_pkg::in_item_t cmd_q;
	logic [TW-1:0] scan_q;
	logic found_q, free_ok_q;
	logic [IW-1:0] hit_q, free_q;
	logic [31:0] rd_val_q;
	logic [IW-1:0] u_idx_q;
	logic u_ex_q;
	logic [31:0] u_val_q;
	tkv_pkg::out_item_t res_q;

	// key read stage of the scan
	logic [KEY_BITS-1:0] key_s1;
	logic [IW-1:0] kidx_s1;
	logic kv_s1;
	logic scan_v_s1;
	logic hit_s1;

	logic [KEY_BITS-1:0] kq;
	logic [IW-1:0] sidx;
	logic [LW-1:0] lptr, ltop;
	assign kq = cmd_q.key[KEY_BITS-1:0];
	assign sidx = scan_q[IW-1:0];
	assign lptr = cnt_q[LW-1:0];
	assign ltop = LW'(cnt_q - CW'(1));
	assign hit_s1 = scan_v_s1 && kv_s1 && !found_q && (key_s1 == kq);

	assign in_stall = (state_q != tkv_pkg::S_IDLE);
	assign out_valid = (state_q == tkv_pkg::S_OUT);
	assign out_item = res_q;

	// Decision for the active command once the scan is done
	logic hit_ex, log_full, do_wr, do_log, do_alloc;
	logic [31:0] wr_val, inc_val;
	logic wr_ex;
	tkv_pkg::out_item_t res_d;
	logic [IW-1:0] tgt;
	assign hit_ex = found_q && ex_q[hit_q];
	assign log_full = trans_q && (cnt_q >= CW'(LOG_DEPTH));
	assign inc_val = rd_val_q + 32'd1;
	assign tgt = found_q ? hit_q : free_q;

	always_comb begin
		do_wr = 1'b0;
		do_alloc = 1'b0;
		wr_val = cmd_q.new_value;
		wr_ex = cmd_q.new_exists;
		res_d = '0;
		res_d.status = tkv_pkg::ST_DONE;
		case (tkv_pkg::cmd_t'(cmd_q.command))
			tkv_pkg::CMD_GET: begin
				if (hit_ex) begin
					res_d.exists = 1'b1;
					res_d.result_value = rd_val_q;
				end else res_d.status = tkv_pkg::ST_ABSENT;
			end
			tkv_pkg::CMD_PUT: begin
				if (!found_q && !free_ok_q) res_d.status = tkv_pkg::ST_TABLE_FULL;
				else if (log_full) begin
					res_d.status = tkv_pkg::ST_LOG_FULL;
					if (hit_ex) begin
						res_d.exists = 1'b1;
						res_d.result_value = rd_val_q;
					end
				end else begin
					do_wr = 1'b1;
					do_alloc = !found_q;
					res_d.exists = cmd_q.new_exists;
					res_d.result_value = cmd_q.new_exists ? cmd_q.new_value : '0;
				end
			end
			tkv_pkg::CMD_INC, tkv_pkg::CMD_DEL: begin
				if (!hit_ex) res_d.status = tkv_pkg::ST_ABSENT;
				else if (log_full) begin
					res_d.status = tkv_pkg::ST_LOG_FULL;
					res_d.exists = 1'b1;
					res_d.result_value = rd_val_q;
				end else begin
					do_wr = 1'b1;
					if (cmd_q.command == tkv_pkg::CMD_INC) begin
						wr_val = inc_val;
						wr_ex = 1'b1;
						res_d.exists = 1'b1;
						res_d.result_value = inc_val;
					end else begin
						wr_val = '0;
						wr_ex = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end
	assign do_log = do_wr && trans_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tkv_pkg::S_IDLE: if (in_valid) begin
				if (in_item.command inside {tkv_pkg::CMD_GET, tkv_pkg::CMD_PUT,
						tkv_pkg::CMD_INC, tkv_pkg::CMD_DEL})
					state_d = tkv_pkg::S_SCAN;
				else if (in_item.command == tkv_pkg::CMD_ABORT && trans_q)
					state_d = tkv_pkg::S_UNDO_RD;
				else state_d = tkv_pkg::S_OUT;
			end
			tkv_pkg::S_SCAN: if (scan_q == TW'(TABLE_DEPTH)) state_d = tkv_pkg::S_ACT;
			tkv_pkg::S_ACT: state_d = tkv_pkg::S_OUT;
			tkv_pkg::S_UNDO_RD:
				state_d = (cnt_q == '0) ? tkv_pkg::S_OUT : tkv_pkg::S_UNDO_WR;
			tkv_pkg::S_UNDO_WR: state_d = tkv_pkg::S_UNDO_RD;
			tkv_pkg::S_OUT: if (!out_stall) state_d = tkv_pkg::S_IDLE;
			default: state_d = tkv_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tkv_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// Control registers: flags, log count, transaction mark, scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ex_q <= '0;
			cnt_q <= '0;
			trans_q <= 1'b0;
			scan_q <= '0;
			found_q <= 1'b0;
			free_ok_q <= 1'b0;
			scan_v_s1 <= 1'b0;
		end else begin
			scan_v_s1 <= (state_q == tkv_pkg::S_SCAN) && (scan_q != TW'(TABLE_DEPTH));
			case (state_q)
				tkv_pkg::S_IDLE: if (in_valid) begin
					scan_q <= '0;
					found_q <= 1'b0;
					free_ok_q <= 1'b0;
					if (in_item.command == tkv_pkg::CMD_START) begin
						trans_q <= 1'b1;
						cnt_q <= '0;
					end else if (in_item.command == tkv_pkg::CMD_COMMIT && trans_q) begin
						trans_q <= 1'b0;
						cnt_q <= '0;
					end
				end
				tkv_pkg::S_SCAN: begin
					if (scan_q != TW'(TABLE_DEPTH)) begin
						if (!free_ok_q && !used_q[sidx]) free_ok_q <= 1'b1;
						scan_q <= scan_q + TW'(1);
					end
					// key compare runs in the cycle after the key read
					if (hit_s1) found_q <= 1'b1;
				end
				tkv_pkg::S_ACT: if (do_wr) begin
					ex_q[tgt] <= wr_ex;
					if (do_alloc) used_q[tgt] <= 1'b1;
					if (do_log) cnt_q <= cnt_q + CW'(1);
				end
				tkv_pkg::S_UNDO_RD: if (cnt_q == '0) trans_q <= 1'b0;
				tkv_pkg::S_UNDO_WR: begin
					ex_q[u_idx_q] <= u_ex_q;
					cnt_q <= cnt_q - CW'(1);
				end
				default: ;
			endcase
		end
	end

	// Payload registers and memories
	always_ff @(posedge clk) begin
		if (state_q == tkv_pkg::S_IDLE && in_valid) cmd_q <= in_item;
		// key read, registered into the compare stage
		if (state_q == tkv_pkg::S_SCAN && scan_q != TW'(TABLE_DEPTH)) begin
			key_s1 <= key_mem[sidx];
			kidx_s1 <= sidx;
			kv_s1 <= used_q[sidx];
			if (!free_ok_q && !used_q[sidx]) free_q <= sidx;
		end
		// value read on a key match; the last compare lands just before S_ACT
		if (hit_s1) begin
			hit_q <= kidx_s1;
			rd_val_q <= val_mem[kidx_s1];
		end
		if (state_q == tkv_pkg::S_ACT && do_wr) begin
			val_mem[tgt] <= wr_val;
			if (do_alloc) key_mem[tgt] <= kq;
			if (do_log) begin
				ulog_idx[lptr] <= tgt;
				ulog_ex[lptr] <= found_q ? ex_q[tgt] : 1'b0;
				ulog_val[lptr] <= found_q ? rd_val_q : 32'd0;
			end
		end
		if (state_q == tkv_pkg::S_UNDO_RD && cnt_q != '0) begin
			u_idx_q <= ulog_idx[ltop];
			u_ex_q <= ulog_ex[ltop];
			u_val_q <= ulog_val[ltop];
		end
		if (state_q == tkv_pkg::S_UNDO_WR) val_mem[u_idx_q] <= u_val_q;
		// result register
		if (state_q == tkv_pkg::S_ACT) res_q <= res_d;
		else if (state_q == tkv_pkg::S_IDLE && in_valid) begin
			res_q.exists <= 1'b0;
			res_q.result_value <= '0;
			res_q.status <= ((in_item.command == tkv_pkg::CMD_COMMIT ||
				in_item.command == tkv_pkg::CMD_ABORT) && !trans_q) ?
				tkv_pkg::ST_NO_TRANS : tkv_pkg::ST_DONE;
		end
	end
endmodule

// ===== hdl/tkv_checker.sv =====
// Port-level checker for the key/value table, bound to the top level.
`include "transactional_key_value_table_top_assert.svh"
module tkv_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input tkv_pkg::out_item_t out_item
);
	`TKV_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item), "result changed while stalled")
	`TKV_ASSERT_IMP(a_busy_out, clk, arst_n, out_valid, in_stall, "input taken while a result waits")
	`TKV_ASSERT_IMP(a_status_rng, clk, arst_n, out_valid, out_item.status <= 3'd4, "bad status code")
	`TKV_ASSERT_IMP(a_absent_zero, clk, arst_n, out_valid && !out_item.exists, out_item.result_value == '0, "absent key with nonzero value")
endmodule

bind transactional_key_value_table_top tkv_port_checker u_tkv_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
